// ===== sv/ihc_pkg.sv =====
package ihc_pkg;

  // Verdict codes, first failing check wins
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_IHL      = 3'd3;
  localparam logic [2:0] ST_HDR_PAST = 3'd4;
  localparam logic [2:0] ST_CHECKSUM = 3'd5;
  localparam logic [2:0] ST_LENGTH   = 3'd6;

  // Header word positions
  localparam logic [4:0] WI_VER_IHL  = 5'd0;
  localparam logic [4:0] WI_TOT_LEN  = 5'd1;
  localparam logic [4:0] WI_IDENT    = 5'd2;
  localparam logic [4:0] WI_FLAGS    = 5'd3;
  localparam logic [4:0] WI_TTL_PROT = 5'd4;
  localparam logic [4:0] WI_CHECKSUM = 5'd5;
  localparam logic [4:0] WI_MAX      = 5'd31;

  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [15:0] MIN_BUF      = 16'd20;

  // Header state captured at the last beat of a packet
  typedef struct packed {
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] ident;
    logic [15:0] flags_off;
    logic [15:0] ttl_prot;
    logic [15:0] chk;
    logic [15:0] sum;
    logic [15:0] buf_bytes;
  } hdr_snap_t;

  // One verdict beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol_number;
    logic [7:0]  hop_limit;
    logic [15:0] packet_ident;
    logic        frag_flag;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
  } verdict_t;

endpackage

// ===== sv/ihc_accum.sv =====
module ihc_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [15:0]       data_word,
  input  logic [15:0]       buffer_bytes,
  input  logic              word_last,
  output logic              snap_valid_r,
  output ihc_pkg::hdr_snap_t snap_r
);
  import ihc_pkg::*;

  logic [4:0]  widx_r, widx_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] ttlp_r, ttlp_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic [3:0]  ihl_eff;
  logic [16:0] raw_sum;
  logic        add_en;
  hdr_snap_t   snap_nxt;

  // Field capture, running ones' complement sum, word counter
  always_comb begin
    vihl_nxt  = vihl_r;
    tlen_nxt  = tlen_r;
    ident_nxt = ident_r;
    flags_nxt = flags_r;
    ttlp_nxt  = ttlp_r;
    chk_nxt   = chk_r;
    case (widx_r)
      WI_VER_IHL:  vihl_nxt  = data_word[15:8];
      WI_TOT_LEN:  tlen_nxt  = data_word;
      WI_IDENT:    ident_nxt = data_word;
      WI_FLAGS:    flags_nxt = data_word;
      WI_TTL_PROT: ttlp_nxt  = data_word;
      WI_CHECKSUM: chk_nxt   = data_word;
      default: ;
    endcase

    ihl_eff = vihl_nxt[3:0];
    add_en  = (widx_r < {ihl_eff, 1'b0}) && (widx_r != WI_CHECKSUM);
    raw_sum = {1'b0, sum_r} + {1'b0, data_word};
    if (!add_en) begin
      sum_nxt = sum_r;
    end else if (raw_sum[16]) begin
      sum_nxt = raw_sum[15:0] + 16'd1;
    end else begin
      sum_nxt = raw_sum[15:0];
    end

    widx_nxt = (widx_r == WI_MAX) ? widx_r : widx_r + 5'd1;

    snap_nxt.ver_ihl   = vihl_nxt;
    snap_nxt.tot_len   = tlen_nxt;
    snap_nxt.ident     = ident_nxt;
    snap_nxt.flags_off = flags_nxt;
    snap_nxt.ttl_prot  = ttlp_nxt;
    snap_nxt.chk       = chk_nxt;
    snap_nxt.sum       = sum_nxt;
    snap_nxt.buf_bytes = buffer_bytes;
  end

  // Packet state: cleared at reset and after each last beat
  always_ff @(posedge clk) begin
    if (!rst_n || (beat && word_last)) begin
      widx_r  <= '0;
      sum_r   <= '0;
      vihl_r  <= '0;
      tlen_r  <= '0;
      ident_r <= '0;
      flags_r <= '0;
      ttlp_r  <= '0;
      chk_r   <= '0;
    end else if (beat) begin
      widx_r  <= widx_nxt;
      sum_r   <= sum_nxt;
      vihl_r  <= vihl_nxt;
      tlen_r  <= tlen_nxt;
      ident_r <= ident_nxt;
      flags_r <= flags_nxt;
      ttlp_r  <= ttlp_nxt;
      chk_r   <= chk_nxt;
    end
  end

  // Snapshot for the verdict stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= beat && word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && word_last) begin
      snap_r <= snap_nxt;
    end
  end

endmodule

// ===== sv/ihc_verdict.sv =====
module ihc_verdict (
  input  ihc_pkg::hdr_snap_t snap,
  output ihc_pkg::verdict_t  verdict
);
  import ihc_pkg::*;

  logic [3:0]  ihl;
  logic [5:0]  hlen;
  logic [15:0] hlen_w;
  logic [15:0] computed;
  logic [2:0]  status;

  // Checks in priority order
  always_comb begin
    ihl      = snap.ver_ihl[3:0];
    hlen     = {ihl, 2'b00};
    hlen_w   = {10'd0, hlen};
    computed = ~snap.sum;

    if (snap.buf_bytes < MIN_BUF) begin
      status = ST_SHORT;
    end else if (snap.ver_ihl[7:4] != IPV4_VERSION) begin
      status = ST_VERSION;
    end else if (ihl < MIN_IHL) begin
      status = ST_IHL;
    end else if (hlen_w > snap.buf_bytes) begin
      status = ST_HDR_PAST;
    end else if (computed != snap.chk) begin
      status = ST_CHECKSUM;
    end else if ((snap.tot_len > snap.buf_bytes) || (snap.tot_len < hlen_w)) begin
      status = ST_LENGTH;
    end else begin
      status = ST_OK;
    end

    verdict = '0;
    verdict.status = status;
    if (status == ST_OK) begin
      verdict.protocol_number = snap.ttl_prot[7:0];
      verdict.hop_limit       = snap.ttl_prot[15:8];
      verdict.packet_ident    = snap.ident;
      verdict.frag_flag       = |snap.flags_off[13:0];
      verdict.header_bytes    = hlen;
      verdict.payload_bytes   = snap.tot_len - hlen_w;
    end
  end

endmodule

// ===== sv/ihc_out_queue.sv =====
module ihc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihc_pkg::verdict_t push_data,
  input  logic              out_stall,
  output logic              head_valid_r,
  output ihc_pkg::verdict_t head_r,
  output logic [1:0]        level
);
  import ihc_pkg::*;

  logic     skid_valid_r;
  verdict_t skid_r;
  logic     pop;

  assign pop   = head_valid_r && !out_stall;
  assign level = {1'b0, head_valid_r} + {1'b0, skid_valid_r};

  // Output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        head_valid_r <= push;
        skid_valid_r <= 1'b0;
      end
    end else if (head_valid_r) begin
      if (push) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      head_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end else if (head_valid_r) begin
      if (push) begin
        skid_r <= push_data;
      end
    end else begin
      head_r <= push_data;
    end
  end

endmodule

// ===== sv/ipv4_header_checker_top.sv =====
// IPv4 header checker.
// Input channel: one 16-bit packet word per beat (in_data_word, first byte in
// bits 15:8), with the buffer byte count and a last-word flag. The header
// fields are captured and the Internet checksum sums ihl*4 bytes minus its field.
// Result channel: one verdict beat per packet, with status and, when status
// is ok, protocol, TTL, identification, fragment flag, header and payload
// lengths (all zero otherwise).
// Throughput: one word per cycle while in_stall is low. The snapshot register
// loads at the edge that accepts the last word; the verdict is formed from it
// combinationally and then loads into the output register or the skid entry.
// Output side has an output register and one skid entry; input keeps flowing
// while a verdict waits, and in_stall rises only while out_stall holds back
// an output stage that could not take one more verdict (a verdict sitting in
// the snapshot stage counts toward that room).
// Reset (rst_n low, synchronous) clears the packet state and drops any
// pending verdicts. Packet state also clears after every last word.
module ipv4_header_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_data_word,
  input  logic [15:0] in_buffer_bytes,
  input  logic        in_word_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_protocol_number,
  output logic [7:0]  out_hop_limit,
  output logic [15:0] out_packet_ident,
  output logic        out_frag_flag,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_bytes
);
  import ihc_pkg::*;

  logic      beat;
  logic      drain;
  logic      snap_valid;
  hdr_snap_t snap;
  verdict_t  verdict;
  verdict_t  head;
  logic [1:0] level;

  // Room check counts the verdict in the snapshot stage and a head leaving now
  assign drain    = out_valid && !out_stall;
  assign in_stall = snap_valid ? ((level == 2'd2) || ((level == 2'd1) && !drain))
                               : ((level == 2'd2) && !drain);
  assign beat     = in_valid && !in_stall;

  ihc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .data_word    (in_data_word),
    .buffer_bytes (in_buffer_bytes),
    .word_last    (in_word_last),
    .snap_valid_r (snap_valid),
    .snap_r       (snap)
  );

  ihc_verdict u_verdict (
    .snap    (snap),
    .verdict (verdict)
  );

  ihc_out_queue u_out_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (snap_valid),
    .push_data    (verdict),
    .out_stall    (out_stall),
    .head_valid_r (out_valid),
    .head_r       (head),
    .level        (level)
  );

  // Result fields
  assign out_status          = head.status;
  assign out_protocol_number = head.protocol_number;
  assign out_hop_limit       = head.hop_limit;
  assign out_packet_ident    = head.packet_ident;
  assign out_frag_flag       = head.frag_flag;
  assign out_header_bytes    = head.header_bytes;
  assign out_payload_bytes   = head.payload_bytes;

endmodule
